// File: sv/hid_output_report_framer_crc32_core_defines.svh
// Assertion macros for the framer RTL.
`ifndef HID_OUTPUT_REPORT_FRAMER_CRC32_CORE_DEFINES_SVH
`define HID_OUTPUT_REPORT_FRAMER_CRC32_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HOFC_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("framer check failed");
`define HOFC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("framer check failed");
`else
`define HOFC_ASSERT_SAME(label, pre, post)
`define HOFC_ASSERT_NEXT(label, pre, post)
`endif

`endif

// File: sv/hofc_pkg.sv
// Package with constants, types and CRC functions of the report framer.
`timescale 1ns / 1ps

package hofc_pkg;

    localparam int BYTE_W           = 8;
    localparam int POS_W            = 8;
    localparam int CFG_W            = 7;
    localparam int SEQ_W            = 4;
    localparam int CRC_W            = 32;
    localparam int COMMON_BYTES_DEF = 69;
    localparam int HDR_BYTES        = 5;
    localparam int CRC_BYTES        = 4;

    localparam logic [POS_W-1:0]  POS_MAX        = 8'hFF;
    localparam logic [CFG_W-1:0]  MIN_LEN_FLOOR  = 7'd11;
    localparam logic [CFG_W-1:0]  MIN_LEN_RESET  = 7'd48;
    localparam logic [BYTE_W-1:0] HDR_REPORT_ID  = 8'h31;
    localparam logic [BYTE_W-1:0] HDR_TAG        = 8'h10;
    localparam logic [BYTE_W-1:0] CRC_SEED_BYTE  = 8'hA2;
    localparam logic [CRC_W-1:0]  CRC_POLY       = 32'hEDB88320;
    localparam logic [CRC_W-1:0]  CRC_INIT       = 32'hFFFFFFFF;

    typedef logic [CRC_W-1:0] crc_table_t [256];

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_HDR,
        EMIT_PASS,
        EMIT_PAD,
        EMIT_CRC,
        EMIT_ABORT
    } emit_kind_t;

    typedef struct packed {
        logic       ready;
        emit_kind_t emit;
        logic       cnt_clr;
        logic       cnt_pad_start;
        logic       seq_adv;
        logic       frame_clr;
    } hofc_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic pos_zero;
        logic pos_pass;
        logic last;
        logic too_short;
        logic pad_needed;
        logic hdr_last;
        logic pad_last;
        logic crc_last;
        logic slot_free;
    } hofc_status_t;

    function automatic logic [CRC_W-1:0] crc_bitwise(logic [CRC_W-1:0] crc_in,
                                                     logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic crc_table_t crc_gen_table();
        crc_table_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = crc_bitwise('0, BYTE_W'(i));
        end
        return t;
    endfunction

    localparam crc_table_t       CRC_TABLE = crc_gen_table();
    localparam logic [CRC_W-1:0] CRC_START = crc_bitwise(CRC_INIT, CRC_SEED_BYTE);

    function automatic logic [CRC_W-1:0] crc_update(logic [CRC_W-1:0] crc_in,
                                                    logic [BYTE_W-1:0] b);
        return (crc_in >> BYTE_W) ^ CRC_TABLE[crc_in[BYTE_W-1:0] ^ b];
    endfunction

endpackage

// File: sv/hofc_if.sv
// Stream interfaces for the report input and the frame output channels.
`timescale 1ns / 1ps

interface hofc_report_if;
    import hofc_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hofc_frame_if;
    import hofc_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              frame_end;
    logic              frame_aborted;

    modport source (output valid, output frame_byte, output frame_end,
                    output frame_aborted, input ready);
    modport sink (input valid, input frame_byte, input frame_end,
                  input frame_aborted, output ready);
endinterface

// File: sv/hofc_ctrl.sv
// Controller state machine that sequences header, data, padding, CRC and abort words.
`timescale 1ns / 1ps

module hofc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hofc_pkg::hofc_status_t status,
    output hofc_pkg::hofc_cmd_t    cmd
);
    import hofc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_HDR,
        S_PASS,
        S_TAIL,
        S_PAD,
        S_CRC,
        S_ABORT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cmd               = '0;
        cmd.emit          = EMIT_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.ready   = 1'b1;
                cmd.cnt_clr = 1'b1;
                if (status.in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (status.pos_zero)
                begin
                    state_next = S_HDR;
                end
                else if (status.pos_pass)
                begin
                    state_next = S_PASS;
                end
                else
                begin
                    state_next = S_TAIL;
                end
            end
            S_HDR:
            begin
                if (status.slot_free)
                begin
                    cmd.emit = EMIT_HDR;
                    if (status.hdr_last)
                    begin
                        state_next = S_TAIL;
                    end
                end
            end
            S_PASS:
            begin
                if (status.slot_free)
                begin
                    cmd.emit   = EMIT_PASS;
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                priority if (!status.last)
                begin
                    state_next = S_IDLE;
                end
                else if (status.too_short)
                begin
                    state_next = S_ABORT;
                end
                else if (status.pad_needed)
                begin
                    cmd.cnt_pad_start = 1'b1;
                    state_next        = S_PAD;
                end
                else
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_CRC;
                end
            end
            S_PAD:
            begin
                if (status.slot_free)
                begin
                    cmd.emit = EMIT_PAD;
                    if (status.pad_last)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = S_CRC;
                    end
                end
            end
            S_CRC:
            begin
                if (status.slot_free)
                begin
                    cmd.emit = EMIT_CRC;
                    if (status.crc_last)
                    begin
                        cmd.seq_adv   = 1'b1;
                        cmd.frame_clr = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            S_ABORT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit      = EMIT_ABORT;
                    cmd.frame_clr = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/hofc_datapath.sv
// Datapath with position, sequence, CRC and counter registers and the output word register.
`timescale 1ns / 1ps

module hofc_datapath #(
    parameter int COMMON_BYTES = hofc_pkg::COMMON_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [hofc_pkg::CFG_W-1:0]   cfg_wdata,
    hofc_report_if.sink                  report,
    hofc_frame_if.source                 frame,
    input  hofc_pkg::hofc_cmd_t          cmd,
    output hofc_pkg::hofc_status_t       status
);
    import hofc_pkg::*;

    localparam int CW = $clog2(COMMON_BYTES);

    logic [CFG_W-1:0]  min_len_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [CRC_W-1:0]  crc_reg;
    logic [CRC_W-1:0]  crc_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  cur_pos_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              last_reg;
    logic [CW-1:0]     cnt_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_end_reg;
    logic              out_abort_reg;

    logic              accept;
    logic [CFG_W-1:0]  eff_min_len;
    logic [BYTE_W-1:0] emit_byte;
    logic [CRC_W-1:0]  crc_shifted;
    logic              emit_end;
    logic              emit_any;

    assign report.ready = cmd.ready;
    assign accept       = report.valid && cmd.ready;
    assign emit_any     = (cmd.emit != EMIT_NONE);

    assign eff_min_len  = (min_len_reg < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : min_len_reg;
    assign crc_shifted  = ~crc_reg >> {cnt_reg[1:0], 3'b000};

    always_comb
    begin
        emit_byte = '0;
        emit_end  = 1'b0;
        unique case (cmd.emit)
            EMIT_HDR:
            begin
                priority if (cnt_reg == CW'(0))
                begin
                    emit_byte = HDR_REPORT_ID;
                end
                else if (cnt_reg == CW'(1))
                begin
                    emit_byte = {seq_reg, {(BYTE_W-SEQ_W){1'b0}}};
                end
                else if (cnt_reg == CW'(2))
                begin
                    emit_byte = HDR_TAG;
                end
                else
                begin
                    emit_byte = '0;
                end
            end
            EMIT_PASS:  emit_byte = data_reg;
            EMIT_PAD:   emit_byte = '0;
            EMIT_CRC:
            begin
                emit_byte = crc_shifted[BYTE_W-1:0];
                emit_end  = status.crc_last;
            end
            EMIT_ABORT: emit_end = 1'b1;
            EMIT_NONE:  emit_byte = '0;
            default:    emit_byte = '0;
        endcase
    end

    always_comb
    begin
        crc_next = crc_reg;
        if (cmd.frame_clr)
        begin
            crc_next = CRC_START;
        end
        else if (cmd.emit == EMIT_HDR || cmd.emit == EMIT_PASS || cmd.emit == EMIT_PAD)
        begin
            crc_next = crc_update(crc_reg, emit_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg   <= MIN_LEN_RESET;
            seq_reg       <= '0;
            crc_reg       <= CRC_START;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_len_reg <= cfg_wdata;
            end
            if (cmd.seq_adv)
            begin
                seq_reg <= seq_reg + SEQ_W'(1);
            end
            crc_reg <= crc_next;
            if (cmd.frame_clr)
            begin
                pos_reg <= '0;
            end
            else if (accept && pos_reg != POS_MAX)
            begin
                pos_reg <= pos_reg + POS_W'(1);
            end
            priority if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_pad_start)
            begin
                cnt_reg <= cur_pos_reg[CW-1:0];
            end
            else if (emit_any)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (emit_any)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (frame.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_pos_reg <= pos_reg;
            data_reg    <= report.data_byte;
            last_reg    <= report.last_byte;
        end
        if (emit_any)
        begin
            out_byte_reg  <= emit_byte;
            out_end_reg   <= emit_end;
            out_abort_reg <= (cmd.emit == EMIT_ABORT);
        end
    end

    assign frame.valid         = out_valid_reg;
    assign frame.frame_byte    = out_byte_reg;
    assign frame.frame_end     = out_end_reg;
    assign frame.frame_aborted = out_abort_reg;

    assign status.in_valid   = report.valid;
    assign status.pos_zero   = (cur_pos_reg == '0);
    assign status.pos_pass   = (cur_pos_reg <= POS_W'(COMMON_BYTES));
    assign status.last       = last_reg;
    assign status.too_short  = (pos_reg < POS_W'(eff_min_len));
    assign status.pad_needed = (cur_pos_reg < POS_W'(COMMON_BYTES));
    assign status.hdr_last   = (cnt_reg == CW'(HDR_BYTES - 1));
    assign status.pad_last   = (cnt_reg == CW'(COMMON_BYTES - 1));
    assign status.crc_last   = (cnt_reg == CW'(CRC_BYTES - 1));
    assign status.slot_free  = !out_valid_reg || frame.ready;

endmodule

// File: sv/hid_output_report_framer_crc32_core.sv
// Top level of the output report framer with CRC-32 trailer.
// The report channel takes one word per handshake: a report byte and a flag on the last byte.
// The frame channel gives one word per handshake: a frame byte, a frame end flag and an
// abort flag that comes only with frame end when the report was shorter than the minimum.
// The user must write the minimum report length through cfg_we and cfg_wdata only while the
// block is idle; the block does not enforce this. The block works on one report byte at a
// time: accept, dispatch, five header words for a report id, a data word for a passed byte
// or none for a dropped byte, then tail. A last byte adds the padding words and four CRC
// words, or one abort word. Every word goes through the output register, one per cycle at
// most, and the controller waits while that register holds a word that the receiver has not
// taken. Reset clears the sequence number, the byte position and the CRC register to its
// seeded start value, and sets the minimum length to 48; the output register is empty. A
// stalled receiver stops the controller at the next word; nothing is lost or repeated.
`timescale 1ns / 1ps

`include "hid_output_report_framer_crc32_core_defines.svh"

module hid_output_report_framer_crc32_core #(
    parameter int COMMON_BYTES = hofc_pkg::COMMON_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [hofc_pkg::CFG_W-1:0] cfg_wdata,
    hofc_report_if.sink                report,
    hofc_frame_if.source               frame
);
    import hofc_pkg::*;

    hofc_cmd_t    cmd;
    hofc_status_t status;

    hofc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    hofc_datapath #(
        .COMMON_BYTES (COMMON_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .report    (report),
        .frame     (frame),
        .cmd       (cmd),
        .status    (status)
    );

    `HOFC_ASSERT_SAME(a_abort_ends, frame.valid && frame.frame_aborted, frame.frame_end)
    `HOFC_ASSERT_SAME(a_abort_zero, frame.valid && frame.frame_aborted, frame.frame_byte == '0)
    `HOFC_ASSERT_NEXT(a_one_at_a_time, report.valid && report.ready, !report.ready)
    `HOFC_ASSERT_SAME(a_no_emit_idle, cmd.ready, cmd.emit == EMIT_NONE)

endmodule

// File: bench/tb.sv
// Self-checking testbench for the output report framer with CRC-32 trailer.
`timescale 1ns / 1ps

module tb;
    import hofc_pkg::*;

    localparam int COMMON       = COMMON_BYTES_DEF;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_AT_WORD = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_BYTES  = 12;
    localparam int LONG_REPORT  = 258;

    typedef struct packed {
        logic [7:0] fbyte;
        logic       fend;
        logic       fabort;
    } frame_word_t;

    typedef enum logic {
        ROW_CFG,
        ROW_BYTE
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  val;
        logic        last;
        logic        typed;
        frame_word_t want;
    } stim_row_t;

    localparam frame_word_t ABORT_MARK = '{8'h00, 1'b1, 1'b1};
    localparam frame_word_t HDR_TAIL   = '{8'h00, 1'b0, 1'b0};
    localparam frame_word_t NO_WORD    = '{8'h00, 1'b0, 1'b0};

    localparam int DIR_ROWS = 16;
    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        '{ROW_BYTE, 8'h00, 1'b1, 1'b1, ABORT_MARK},
        '{ROW_CFG,  8'h00, 1'b0, 1'b0, NO_WORD},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b1, HDR_TAIL},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, NO_WORD},
        '{ROW_BYTE, 8'h80, 1'b0, 1'b0, NO_WORD},
        '{ROW_BYTE, 8'h01, 1'b0, 1'b0, NO_WORD},
        '{ROW_BYTE, 8'h7F, 1'b0, 1'b0, NO_WORD},
        '{ROW_BYTE, 8'hFE, 1'b0, 1'b0, NO_WORD},
        '{ROW_BYTE, 8'h55, 1'b0, 1'b0, NO_WORD},
        '{ROW_BYTE, 8'hAA, 1'b0, 1'b0, NO_WORD},
        '{ROW_BYTE, 8'h0F, 1'b0, 1'b0, NO_WORD},
        '{ROW_BYTE, 8'hF0, 1'b1, 1'b0, NO_WORD},
        '{ROW_CFG,  8'h7F, 1'b0, 1'b0, NO_WORD},
        '{ROW_BYTE, 8'h31, 1'b0, 1'b1, HDR_TAIL},
        '{ROW_BYTE, 8'hC3, 1'b1, 1'b1, ABORT_MARK}
    };

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_W-1:0]         cfg_wdata;

    hofc_report_if rpt_if ();
    hofc_frame_if  frm_if ();

    hid_output_report_framer_crc32_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .report    (rpt_if),
        .frame     (frm_if)
    );

    frame_word_t      frame_words_due [$];
    logic [3:0]       seq_num;
    logic [CRC_W-1:0] crc_acc;
    logic [POS_W-1:0] byte_pos;
    logic [CFG_W-1:0] min_len_reg;

    int cycles = 0;
    int mismatches = 0;
    int words_checked = 0;
    int bytes_sent;
    int reports_sent;
    int frames_done;
    int frames_aborted;
    int settings_used;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d words outstanding.",
                     cycles, frame_words_due.size());
            $display("[hid_output_report_framer_crc32_core] ERROR");
            $finish;
        end
    end

    function automatic logic [CRC_W-1:0] crc_shift(input logic [CRC_W-1:0] acc,
                                                   input logic [7:0] b);
        logic [CRC_W-1:0] r;
        logic             fb;
        int               k;
        r = acc;
        for (k = 0; k < 8; k++)
        begin
            fb = r[0] ^ b[k];
            r  = r >> 1;
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] crc_seeded();
        return crc_shift(CRC_INIT, CRC_SEED_BYTE);
    endfunction

    task automatic push_frame_data(input logic [7:0] b);
        crc_acc = crc_shift(crc_acc, b);
        frame_words_due.push_back('{b, 1'b0, 1'b0});
    endtask

    task automatic frame_report_byte(input logic [7:0] d, input logic l);
        logic [POS_W-1:0] cnt;
        logic [CFG_W-1:0] eff_min;
        logic [CRC_W-1:0] fin;
        int               done;
        int               k;
        if (byte_pos == 0)
        begin
            push_frame_data(HDR_REPORT_ID);
            push_frame_data({seq_num, 4'h0});
            push_frame_data(HDR_TAG);
            push_frame_data(8'h00);
            push_frame_data(8'h00);
        end
        else if (byte_pos <= COMMON)
        begin
            push_frame_data(d);
        end
        cnt = (byte_pos == POS_MAX) ? POS_MAX : byte_pos + 8'd1;
        if (!l)
        begin
            byte_pos = cnt;
        end
        else
        begin
            eff_min = (min_len_reg < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : min_len_reg;
            if (cnt < eff_min)
            begin
                frame_words_due.push_back(ABORT_MARK);
                frames_aborted++;
            end
            else
            begin
                done = (byte_pos < COMMON) ? int'(byte_pos) : COMMON;
                while (done < COMMON)
                begin
                    push_frame_data(8'h00);
                    done++;
                end
                fin = ~crc_acc;
                for (k = 0; k < 4; k++)
                    frame_words_due.push_back('{fin[8*k +: 8], k == 3, 1'b0});
                seq_num = seq_num + 4'd1;
                frames_done++;
            end
            crc_acc  = crc_seeded();
            byte_pos = '0;
        end
    endtask

    task automatic put_byte(input logic [7:0] d, input logic l, input logic typed,
                            input frame_word_t want, input logic calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            rpt_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rpt_if.valid     <= 1'b1;
        rpt_if.data_byte <= d;
        rpt_if.last_byte <= l;
        do
            @(posedge clk);
        while (!rpt_if.ready);
        frame_report_byte(d, l);
        if (typed)
            frame_words_due[frame_words_due.size() - 1] = want;
        bytes_sent++;
        if (l)
            reports_sent++;
        @(negedge clk);
    endtask

    task automatic wait_frames_out();
        rpt_if.valid <= 1'b0;
        while (frame_words_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_min_len(input logic [CFG_W-1:0] v);
        wait_frames_out();
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we      <= 1'b0;
        min_len_reg = v;
        settings_used++;
    endtask

    task automatic send_report(input int len);
        logic calm;
        int   j;
        calm = ($urandom_range(0, 3) == 0);
        for (j = 0; j < len; j++)
            put_byte(8'($urandom_range(0, 255)), j == len - 1, 1'b0, NO_WORD, calm);
    endtask

    task automatic log_fault(input string what, input frame_word_t want,
                             input frame_word_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s at word %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b", what,
                     words_checked, want.fbyte, want.fend, want.fabort,
                     got.fbyte, got.fend, got.fabort);
    endtask

    initial
    begin
        frame_word_t got;
        frame_word_t want;
        logic        snk_calm;
        logic        held;
        int          gap;
        frm_if.ready <= 1'b0;
        snk_calm     = 1'b0;
        held         = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (words_checked % 50 == 0)
                snk_calm = ($urandom_range(0, 3) == 0);
            gap = snk_calm ? 0 : $urandom_range(0, 5);
            if (!held && words_checked >= HOLD_AT_WORD)
            begin
                held = 1'b1;
                gap  = gap + HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                frm_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            frm_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!frm_if.valid);
            got = '{frm_if.frame_byte, frm_if.frame_end, frm_if.frame_aborted};
            if (frame_words_due.size() == 0)
            begin
                log_fault("Unexpected word", NO_WORD, got);
            end
            else
            begin
                want = frame_words_due.pop_front();
                if (got !== want)
                    log_fault("Mismatch", want, got);
            end
            words_checked++;
            @(negedge clk);
        end
    end

    initial
    begin
        int          i;
        int          p;
        int          sent;
        int          len;
        int          pick;
        int          eff;
        logic        paused;
        logic [CFG_W-1:0] v;
        int          plan [6];
        rpt_if.valid     <= 1'b0;
        rpt_if.data_byte <= '0;
        rpt_if.last_byte <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        rst_n            = 1'b0;
        bytes_sent       = 0;
        reports_sent     = 0;
        frames_done      = 0;
        frames_aborted   = 0;
        settings_used    = 0;
        paused           = 1'b0;
        plan             = '{48, 11, 70, 127, 5, 0};
        seq_num          = '0;
        crc_acc          = crc_seeded();
        byte_pos         = '0;
        min_len_reg      = MIN_LEN_RESET;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (DIR_TABLE[i].kind == ROW_CFG)
                write_min_len(DIR_TABLE[i].val[CFG_W-1:0]);
            else
                put_byte(DIR_TABLE[i].val, DIR_TABLE[i].last, DIR_TABLE[i].typed,
                         DIR_TABLE[i].want, 1'b0);
        end

        for (p = 0; p < 6; p++)
        begin
            v = CFG_W'(plan[p]);
            write_min_len(v);
            eff  = (v < MIN_LEN_FLOOR) ? int'(MIN_LEN_FLOOR) : int'(v);
            sent = 0;
            if (p == 1)
            begin
                send_report(LONG_REPORT);
                sent = LONG_REPORT;
            end
            while (sent < PHASE_BYTES)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 8 && eff <= COMMON + 1)
                    len = $urandom_range((eff > 3) ? eff - 2 : 1, eff + 2);
                else
                    len = $urandom_range(1, 12);
                send_report(len);
                sent = sent + len;
                if ((p == 2 && !paused) || $urandom_range(0, 9) == 0)
                begin
                    paused = 1'b1;
                    wait_frames_out();
                end
            end
        end

        wait_frames_out();
        repeat (40) @(posedge clk);
        $display("Sent %0d report bytes in %0d reports across %0d register settings.",
                 bytes_sent, reports_sent, settings_used);
        $display("Checked %0d frame words: %0d complete frames, %0d aborted frames.",
                 words_checked, frames_done, frames_aborted);
        if (mismatches == 0 && frame_words_due.size() == 0)
            $display("[hid_output_report_framer_crc32_core] OK");
        else
            $display("[hid_output_report_framer_crc32_core] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/hofc_pkg.sv
sv/hofc_if.sv
sv/hofc_ctrl.sv
sv/hofc_datapath.sv
sv/hid_output_report_framer_crc32_core.sv
bench/tb.sv
